### hw/rtl/ffea_pkg.sv
// Package for the first-fit extent allocator: table geometry, status codes,
// sequencer states and the table write command. No dependencies.
package ffea_pkg;

   localparam int MEM_WORDS   = 65536;
   localparam int MAX_EXTENTS = 16;

   localparam int ADDR_W = $clog2(MEM_WORDS);
   localparam int SIZE_W = ADDR_W + 1;
   localparam int END_W  = ADDR_W + 2;
   localparam int IDX_W  = $clog2(MAX_EXTENTS);
   localparam int CNT_W  = IDX_W + 1;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOFIT    = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_FREE_SCAN,
      S_FREE_DECIDE,
      S_SHIFT_DOWN,
      S_SHIFT_UP,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
   } tbl_wr_type;

endpackage

### hw/rtl/ffea_extent_table.sv
// Extent table: base and size of each free extent, one write port and one
// combinational read port. Depends on ffea_pkg.
module ffea_extent_table (
   input  logic                       clock,
   input  logic                       reset,
   input  ffea_pkg::tbl_wr_type       wr,
   input  logic [ffea_pkg::IDX_W-1:0] rd_idx,
   output logic [ffea_pkg::ADDR_W-1:0] rd_base,
   output logic [ffea_pkg::SIZE_W-1:0] rd_size
);
   import ffea_pkg::*;

   logic [ADDR_W-1:0] base_ff [MAX_EXTENTS];
   logic [SIZE_W-1:0] size_ff [MAX_EXTENTS];

   // After reset the whole memory is one extent at entry 0; other entries
   // are only read once they have been written.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff[0] <= '0;
         size_ff[0] <= SIZE_W'(MEM_WORDS);
      end else if (wr.en) begin
         base_ff[wr.idx] <= wr.base;
         size_ff[wr.idx] <= wr.size;
      end
   end

   assign rd_base = base_ff[rd_idx];
   assign rd_size = size_ff[rd_idx];

endmodule

### hw/rtl/first_fit_extent_allocator.sv
// Top level of the first-fit extent allocator: sequencer, scan and shift
// control, free-word total and result register. Depends on ffea_pkg and
// ffea_extent_table.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   req     | in        | req_valid, req_ready, req_kind, req_seg_base,
//           |           | req_seg_size
//   rsp     | out       | rsp_valid, rsp_ready, rsp_status, rsp_alloc_base,
//           |           | rsp_free_total
//
// In a transaction the table is scanned one entry per cycle, then entries
// are shifted one per cycle when an extent is removed or inserted. req_ready
// is high only while the sequencer is idle. A finished result waits in the
// output register, and the next request is taken meanwhile; the sequencer
// holds its next result until that register drains. Reset is synchronous and
// leaves one extent covering the whole memory.
module first_fit_extent_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [ffea_pkg::ADDR_W-1:0] req_seg_base,
   input  logic [ffea_pkg::SIZE_W-1:0] req_seg_size,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [ffea_pkg::ADDR_W-1:0] rsp_alloc_base,
   output logic [ffea_pkg::SIZE_W-1:0] rsp_free_total
);
   import ffea_pkg::*;

   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [END_W-1:0]  end_ff, end_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] total_ff, total_in;
   logic              has_prev_ff, has_prev_in;
   logic [ADDR_W-1:0] prev_base_ff, prev_base_in;
   logic [SIZE_W-1:0] prev_size_ff, prev_size_in;
   logic [SIZE_W-1:0] prev_end_ff, prev_end_in;
   logic              has_next_ff, has_next_in;
   logic [ADDR_W-1:0] next_base_ff, next_base_in;
   logic [SIZE_W-1:0] next_size_ff, next_size_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] abase_ff, abase_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_base_ff, rsp_base_in;
   logic [SIZE_W-1:0] rsp_total_ff, rsp_total_in;

   tbl_wr_type        tbl_wr;
   logic [IDX_W-1:0]  rd_idx;
   logic [ADDR_W-1:0] rd_base;
   logic [SIZE_W-1:0] rd_size;

   logic              req_fire;
   logic [END_W-1:0]  req_end;
   logic              req_skip_alloc;
   logic              req_skip_free;
   logic [CNT_W-1:0]  idx_inc;
   logic [CNT_W-1:0]  idx_dec;
   logic              scan_live;
   logic              fit;
   logic              exact;
   logic              before_pos;
   logic [SIZE_W-1:0] base_ext;
   logic [END_W-1:0]  next_base_ext;
   logic              overlap;
   logic              join_prev;
   logic              join_next;
   logic              table_full;
   logic              shift_down_more;
   logic              reply_load;

   ffea_extent_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd_idx  (rd_idx),
      .rd_base (rd_base),
      .rd_size (rd_size)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign req_fire       = req_valid && req_ready;
   assign req_end        = {2'b00, req_seg_base} + {1'b0, req_seg_size};
   assign req_skip_alloc = (req_seg_size == '0);
   assign req_skip_free  = (req_seg_size == '0) || (req_end > END_W'(MEM_WORDS));

   assign idx_inc         = idx_ff + 1'b1;
   assign idx_dec         = idx_ff - 1'b1;
   assign scan_live       = (idx_ff < count_ff);
   assign fit             = (rd_size >= size_ff);
   assign exact           = (rd_size == size_ff);
   assign before_pos      = scan_live && (rd_base <= base_ff);
   assign base_ext        = {1'b0, base_ff};
   assign next_base_ext   = {2'b00, next_base_ff};
   assign overlap         = (has_prev_ff && (prev_end_ff > base_ext)) ||
                            (has_next_ff && (end_ff > next_base_ext));
   assign join_prev       = has_prev_ff && (prev_end_ff == base_ext);
   assign join_next       = has_next_ff && (end_ff == next_base_ext);
   assign table_full      = (count_ff == CNT_W'(MAX_EXTENTS));
   assign shift_down_more = (idx_inc < count_ff);
   assign reply_load      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (state_ff)
         S_SHIFT_DOWN: rd_idx = idx_inc[IDX_W-1:0];
         S_SHIFT_UP:   rd_idx = idx_dec[IDX_W-1:0];
         default:      rd_idx = idx_ff[IDX_W-1:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_ALLOC) begin
                  state_in = req_skip_alloc ? S_REPLY : S_ALLOC_SCAN;
               end else begin
                  state_in = req_skip_free ? S_REPLY : S_FREE_SCAN;
               end
            end
         end
         S_ALLOC_SCAN: begin
            if (!scan_live) begin
               state_in = S_REPLY;
            end else if (fit) begin
               state_in = exact ? S_SHIFT_DOWN : S_REPLY;
            end
         end
         S_FREE_SCAN: begin
            if (!before_pos) begin
               state_in = S_FREE_DECIDE;
            end
         end
         S_FREE_DECIDE: begin
            if (overlap) begin
               state_in = S_REPLY;
            end else if (join_prev && join_next) begin
               state_in = S_SHIFT_DOWN;
            end else if (join_prev || join_next || table_full) begin
               state_in = S_REPLY;
            end else begin
               state_in = S_SHIFT_UP;
            end
         end
         S_SHIFT_DOWN: begin
            if (!shift_down_more) begin
               state_in = S_REPLY;
            end
         end
         S_SHIFT_UP: begin
            if (idx_ff <= pos_ff) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (reply_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      kind_in       = kind_ff;
      base_in       = base_ff;
      size_in       = size_ff;
      end_in        = end_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      has_prev_in   = has_prev_ff;
      prev_base_in  = prev_base_ff;
      prev_size_in  = prev_size_ff;
      prev_end_in   = prev_end_ff;
      has_next_in   = has_next_ff;
      next_base_in  = next_base_ff;
      next_size_in  = next_size_ff;
      status_in     = status_ff;
      abase_in      = abase_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_total_in  = rsp_total_ff;
      tbl_wr        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in     = req_kind;
               base_in     = req_seg_base;
               size_in     = req_seg_size;
               end_in      = req_end;
               idx_in      = '0;
               has_prev_in = 1'b0;
               has_next_in = 1'b0;
               abase_in    = '0;
               status_in   = STAT_OK;
               if ((req_kind == KIND_ALLOC) && req_skip_alloc) begin
                  status_in = STAT_NOFIT;
               end
            end
         end
         S_ALLOC_SCAN: begin
            if (!scan_live) begin
               status_in = STAT_NOFIT;
            end else if (fit) begin
               abase_in = rd_base;
               total_in = total_ff - size_ff;
               if (!exact) begin
                  tbl_wr.en   = 1'b1;
                  tbl_wr.idx  = idx_ff[IDX_W-1:0];
                  tbl_wr.base = rd_base + size_ff[ADDR_W-1:0];
                  tbl_wr.size = rd_size - size_ff;
               end
            end else begin
               idx_in = idx_inc;
            end
         end
         S_FREE_SCAN: begin
            if (before_pos) begin
               has_prev_in  = 1'b1;
               prev_base_in = rd_base;
               prev_size_in = rd_size;
               prev_end_in  = {1'b0, rd_base} + rd_size;
               idx_in       = idx_inc;
            end else begin
               has_next_in  = scan_live;
               next_base_in = rd_base;
               next_size_in = rd_size;
            end
         end
         S_FREE_DECIDE: begin
            pos_in = idx_ff;
            if (!overlap) begin
               if (join_prev) begin
                  tbl_wr.en   = 1'b1;
                  tbl_wr.idx  = idx_dec[IDX_W-1:0];
                  tbl_wr.base = prev_base_ff;
                  tbl_wr.size = join_next ? prev_size_ff + size_ff + next_size_ff
                                          : prev_size_ff + size_ff;
                  total_in    = total_ff + size_ff;
               end else if (join_next) begin
                  tbl_wr.en   = 1'b1;
                  tbl_wr.idx  = idx_ff[IDX_W-1:0];
                  tbl_wr.base = base_ff;
                  tbl_wr.size = next_size_ff + size_ff;
                  total_in    = total_ff + size_ff;
               end else if (table_full) begin
                  status_in = STAT_OVERFLOW;
               end else begin
                  idx_in   = count_ff;
                  total_in = total_ff + size_ff;
               end
            end
         end
         S_SHIFT_DOWN: begin
            if (shift_down_more) begin
               tbl_wr.en   = 1'b1;
               tbl_wr.idx  = idx_ff[IDX_W-1:0];
               tbl_wr.base = rd_base;
               tbl_wr.size = rd_size;
               idx_in      = idx_inc;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         S_SHIFT_UP: begin
            tbl_wr.en  = 1'b1;
            tbl_wr.idx = idx_ff[IDX_W-1:0];
            if (idx_ff > pos_ff) begin
               tbl_wr.base = rd_base;
               tbl_wr.size = rd_size;
               idx_in      = idx_dec;
            end else begin
               tbl_wr.base = base_ff;
               tbl_wr.size = size_ff;
               count_in    = count_ff + 1'b1;
            end
         end
         S_REPLY: begin
            if (reply_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_base_in   = abase_ff;
               rsp_total_in  = total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         total_ff     <= SIZE_W'(MEM_WORDS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      base_ff       <= base_in;
      size_ff       <= size_in;
      end_ff        <= end_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      has_prev_ff   <= has_prev_in;
      prev_base_ff  <= prev_base_in;
      prev_size_ff  <= prev_size_in;
      prev_end_ff   <= prev_end_in;
      has_next_ff   <= has_next_in;
      next_base_ff  <= next_base_in;
      next_size_ff  <= next_size_in;
      status_ff     <= status_in;
      abase_ff      <= abase_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_alloc_base = rsp_base_ff;
   assign rsp_free_total = rsp_total_ff;

   // The extent count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EXTENTS))
      else $error("extent count exceeds table depth");

   // The free-word total never exceeds the memory size.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= SIZE_W'(MEM_WORDS))
      else $error("free-word total exceeds memory size");

   // A request is never taken twice in a row: req_ready is low once a request has been taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken twice in a row");

   // Only a kind-specific path may report an overflow or a no-fit status.
   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY) |->
         ((kind_ff == KIND_ALLOC) ? (status_ff != STAT_OVERFLOW)
                                  : (status_ff != STAT_NOFIT)))
      else $error("status does not match request kind");

endmodule
